@@ src/rqs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared constants, state encoding and control structs for the read quality
// statistics block.
// ----------------------------------------------------------------------------
package rqs_pkg;

    localparam int MAX_READ_LEN_DEF     = 256;
    localparam int QUALITY_MAX_DEF      = 93;
    localparam int GC_FRACTION_BITS_DEF = 16;

    localparam int GC_BIN_COUNT = 101;
    localparam int GC_PERCENT   = 100;
    localparam int BASE_CODES   = 5;
    localparam int COUNTER_NUM  = 3;

    localparam int QUAL_W     = 7;
    localparam int CHAR_W     = 8;
    localparam int CODE_W     = 3;
    localparam int SEL_W      = 3;
    localparam int IDX_W      = 11;
    localparam int INREADS_W  = 8;
    localparam int DATA_W     = 48;
    localparam int S_TDATA_W  = 40;
    localparam int COUNTER_W  = 40;
    localparam int LEN_HIST_W = 32;
    localparam int QHIST_W    = 40;
    localparam int GC_BIN_W   = 48;
    localparam int BPC_W      = 32;
    localparam int QPS_W      = 40;

    localparam logic [QUAL_W-1:0] QOFF_RESET = 7'd33;

    localparam logic CMD_BASE  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [CODE_W-1:0] BASE_A = 3'd0;
    localparam logic [CODE_W-1:0] BASE_C = 3'd1;
    localparam logic [CODE_W-1:0] BASE_G = 3'd2;
    localparam logic [CODE_W-1:0] BASE_T = 3'd3;
    localparam logic [CODE_W-1:0] BASE_N = 3'd4;

    localparam logic [SEL_W-1:0] SEL_COUNTERS = 3'd0;
    localparam logic [SEL_W-1:0] SEL_LENGTH   = 3'd1;
    localparam logic [SEL_W-1:0] SEL_QUALITY  = 3'd2;
    localparam logic [SEL_W-1:0] SEL_GC       = 3'd3;
    localparam logic [SEL_W-1:0] SEL_BASES    = 3'd4;
    localparam logic [SEL_W-1:0] SEL_QSUMS    = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ITEM,
        ST_FETCH,
        ST_BASE_WR,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_DIV_LO_GO,
        ST_DIV_LO,
        ST_DIV_HI,
        ST_GC_SETUP,
        ST_GC_RD,
        ST_GC_WR
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic base_wr;
        logic fin_wr;
        logic div_go_lo;
        logic cap_lo;
        logic cap_hi;
        logic gc_setup;
        logic gc_wr;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_fetch;
        logic finish;
        logic spread;
        logic div_done;
        logic gc_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

@@ src/read_quality_statistics.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// read_quality_statistics
// Per-base sequencing read statistics with word read-out.
//
// Channel  Dir  Beat contents
// s_*      in   tuser cmd; tlast end_of_read; tdata base/quality/flags/table
// m_*      out  tdata read_data; tuser index_error
// cfg_*    in   quality_offset write
//
// A new beat is taken only after the last is processed, end of read included.
// A sampled read with A/C/G/T bases ends with two divisions (DW = dividend
// bits, 32 at defaults) and a walk over the GC bins that it touches.
// After reset a clearing pass over the deepest table depth (1280 at defaults)
// runs with s_tready low. An unaccepted m beat holds; input is still taken.
// ----------------------------------------------------------------------------
module read_quality_statistics #(
    parameter int MAX_READ_LEN     = rqs_pkg::MAX_READ_LEN_DEF,
    parameter int QUALITY_MAX      = rqs_pkg::QUALITY_MAX_DEF,
    parameter int GC_FRACTION_BITS = rqs_pkg::GC_FRACTION_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // base_code[2:0] quality_char[10:3] no_base[11] sampled[12]
    // input_reads[20:13] table_select[23:21] table_index[34:24]
    input  wire logic [rqs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,  // cmd
    input  wire logic                          s_tlast,  // end_of_read
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rqs_pkg::DATA_W-1:0]         m_tdata,  // read_data[47:0]
    output logic                               m_tuser,  // index_error
    input  wire logic                          cfg_wen,
    input  wire logic [rqs_pkg::QUAL_W-1:0]    cfg_wdata
);
    import rqs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    rqs_datapath #(
        .MAX_READ_LEN     (MAX_READ_LEN),
        .QUALITY_MAX      (QUALITY_MAX),
        .GC_FRACTION_BITS (GC_FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

@@ src/rqs_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rqs_divider #(
    parameter int DW  = 36,
    parameter int DVW = 10
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [DW-1:0]  dividend,
    input  wire logic [DVW-1:0] divisor,
    output logic                done,
    output logic [DW-1:0]       quotient
);
    localparam int CNTW = $clog2(DW + 1);

    logic [DVW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DVW:0]    trial;
    logic [DVW:0]    diff;
    logic            fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNTW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVW-1:0] : trial[DVW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ src/rqs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_ctrl
// Sequencer: clearing, read-out, base and end-of-read update, GC spread walk.
// ----------------------------------------------------------------------------
module rqs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire rqs_pkg::dp_status_t status,
    output rqs_pkg::dp_cmd_t         cmd,
    output logic                     s_tready
);
    import rqs_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:      if (s_tvalid) state_next = ST_ITEM;
            ST_ITEM:      state_next = status.is_fetch ? ST_FETCH : ST_BASE_WR;
            ST_FETCH:     if (status.out_free) state_next = ST_IDLE;
            ST_BASE_WR:   state_next = status.finish ? ST_FIN_RD : ST_IDLE;
            ST_FIN_RD:    state_next = ST_FIN_WR;
            ST_FIN_WR:    state_next = status.spread ? ST_DIV_LO_GO : ST_IDLE;
            ST_DIV_LO_GO: state_next = ST_DIV_LO;
            ST_DIV_LO:    if (status.div_done) state_next = ST_DIV_HI;
            ST_DIV_HI:    if (status.div_done) state_next = ST_GC_SETUP;
            ST_GC_SETUP:  state_next = ST_GC_RD;
            ST_GC_RD:     state_next = ST_GC_WR;
            ST_GC_WR:     state_next = status.gc_last ? ST_IDLE : ST_GC_RD;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:     cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_FETCH:     cmd.load_out = status.out_free;
            ST_BASE_WR:   cmd.base_wr = 1'b1;
            ST_FIN_WR:    cmd.fin_wr = 1'b1;
            ST_DIV_LO_GO: cmd.div_go_lo = 1'b1;
            ST_DIV_LO:    cmd.cap_lo = status.div_done;
            ST_DIV_HI:    cmd.cap_hi = status.div_done;
            ST_GC_SETUP:  cmd.gc_setup = 1'b1;
            ST_GC_WR:     cmd.gc_wr = 1'b1;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

@@ src/rqs_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rqs_datapath
// Item registers, statistics memories, counters, GC divider and output beat.
// ----------------------------------------------------------------------------
module rqs_datapath #(
    parameter int MAX_READ_LEN     = rqs_pkg::MAX_READ_LEN_DEF,
    parameter int QUALITY_MAX      = rqs_pkg::QUALITY_MAX_DEF,
    parameter int GC_FRACTION_BITS = rqs_pkg::GC_FRACTION_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rqs_pkg::dp_cmd_t                   cmd,
    output rqs_pkg::dp_status_t                     status,
    input  wire logic [rqs_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                               s_tuser,
    input  wire logic                               s_tlast,
    input  wire logic                               cfg_wen,
    input  wire logic [rqs_pkg::QUAL_W-1:0]         cfg_wdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [rqs_pkg::DATA_W-1:0]              m_tdata,
    output logic                                    m_tuser
);
    import rqs_pkg::*;

    localparam int F        = GC_FRACTION_BITS;
    localparam int PW       = $clog2(MAX_READ_LEN + 1);
    localparam int POS_ENT  = MAX_READ_LEN * BASE_CODES;
    localparam int SW       = $clog2(POS_ENT);
    localparam int QH_DEPTH = QUALITY_MAX + 1;
    localparam int QAW      = $clog2(QH_DEPTH);
    localparam int LH_DEPTH = MAX_READ_LEN + 1;
    localparam int GAW      = $clog2(GC_BIN_COUNT);
    localparam int NUMW     = $clog2(GC_PERCENT * (2 * MAX_READ_LEN + 1) + 1);
    localparam int DW       = NUMW + F;
    localparam int DVW      = PW + 1;
    localparam int FXW      = F + 8;
    localparam int BINW     = 8;
    localparam int CLR_A    = (POS_ENT > LH_DEPTH) ? POS_ENT : LH_DEPTH;
    localparam int CLR_B    = (QH_DEPTH > GC_BIN_COUNT) ? QH_DEPTH : GC_BIN_COUNT;
    localparam int CLR_DEPTH = (CLR_A > CLR_B) ? CLR_A : CLR_B;
    localparam int CW       = $clog2(CLR_DEPTH);

    localparam logic [FXW-1:0] FX_ONE  = FXW'(1) << F;
    localparam logic [FXW-1:0] FX_TOP  = FXW'(GC_PERCENT) << F;
    localparam logic [DW-1:0]  DIV_TOP = DW'(GC_PERCENT) << F;

    // item
    logic                 item_cmd_reg;
    logic [CODE_W-1:0]    item_code_reg;
    logic [CHAR_W-1:0]    item_qchar_reg;
    logic                 item_nobase_reg;
    logic                 item_eor_reg;
    logic                 item_smp_reg;
    logic [INREADS_W-1:0] item_inreads_reg;
    logic [SEL_W-1:0]     item_tsel_reg;
    logic [IDX_W-1:0]     item_tidx_reg;

    // read state
    logic [QUAL_W-1:0]    qoff_reg;
    logic [PW-1:0]        pos_reg;
    logic                 rsmp_reg;
    logic [PW-1:0]        gc_tally_reg;
    logic [PW-1:0]        at_tally_reg;
    logic [COUNTER_W-1:0] counters_reg [COUNTER_NUM];
    logic [CW-1:0]        clr_idx_reg;

    // spread
    logic [PW-1:0]        gc_cap_reg;
    logic [PW-1:0]        len_cap_reg;
    logic                 full_reg;
    logic [FXW-1:0]       lo_fx_reg;
    logic [FXW-1:0]       hi_fx_reg;
    logic [BINW-1:0]      walk_bin_reg;
    logic [BINW-1:0]      walk_end_reg;

    // output
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_data_reg;
    logic                 out_err_reg;

    // memories
    logic [LEN_HIST_W-1:0] lh_mem  [LH_DEPTH];
    logic [QHIST_W-1:0]    qh_mem  [QH_DEPTH];
    logic [GC_BIN_W-1:0]   gc_mem  [GC_BIN_COUNT];
    logic [BPC_W-1:0]      bpc_mem [POS_ENT];
    logic [QPS_W-1:0]      qps_mem [POS_ENT];
    logic [LEN_HIST_W-1:0] lh_rdata;
    logic [QHIST_W-1:0]    qh_rdata;
    logic [GC_BIN_W-1:0]   gc_rdata;
    logic [BPC_W-1:0]      bpc_rdata;
    logic [QPS_W-1:0]      qps_rdata;

    logic [PW-1:0]    lh_ra;
    logic [QAW-1:0]   qh_ra;
    logic [GAW-1:0]   gc_ra;
    logic [SW-1:0]    pos_ra;
    logic             clr_active;

    // combinational
    logic [CODE_W-1:0] code_c;
    logic [QUAL_W-1:0] qc;
    logic [CHAR_W:0]   qdiff;
    logic [SW-1:0]     slot;
    logic              eff_smp;
    logic              room;
    logic              take;
    logic [PW:0]       len_sum;
    logic [NUMW-1:0]   num_lo;
    logic [NUMW-1:0]   num_hi;
    logic [DW-1:0]     dividend;
    logic [DVW-1:0]    divisor;
    logic              div_start;
    logic              div_done;
    logic [DW-1:0]     quotient;
    logic [BINW-1:0]   lo_i;
    logic [BINW-1:0]   hi_i;
    logic [FXW-1:0]    amt;
    logic [DATA_W-1:0] fetch_val;
    logic              fetch_err;

    always_comb
    begin
        code_c = (item_code_reg > BASE_N) ? BASE_N : item_code_reg;
        qdiff  = {1'b0, item_qchar_reg} - {2'b00, qoff_reg};
        if (item_qchar_reg < {1'b0, qoff_reg})
            qc = '0;
        else if (qdiff > (CHAR_W+1)'(QUALITY_MAX))
            qc = QUAL_W'(QUALITY_MAX);
        else
            qc = qdiff[QUAL_W-1:0];
        slot    = SW'({pos_reg, 2'b00} + (PW+2)'(pos_reg) + (PW+2)'(code_c));
        eff_smp = (pos_reg == '0) ? item_smp_reg : rsmp_reg;
        room    = !item_nobase_reg && (pos_reg < PW'(MAX_READ_LEN));
        take    = room && eff_smp;
        len_sum = {1'b0, gc_tally_reg} + {1'b0, at_tally_reg};
    end

    always_comb
    begin
        clr_active = cmd.clear_step;
        lh_ra  = (item_cmd_reg == CMD_FETCH) ? PW'(item_tidx_reg) : pos_reg;
        qh_ra  = (item_cmd_reg == CMD_FETCH) ? QAW'(item_tidx_reg) : QAW'(qc);
        gc_ra  = (item_cmd_reg == CMD_FETCH) ? GAW'(item_tidx_reg) : GAW'(walk_bin_reg);
        pos_ra = (item_cmd_reg == CMD_FETCH) ? SW'(item_tidx_reg) : slot;
    end

    // divider operands
    always_comb
    begin
        num_lo    = (gc_cap_reg == '0) ? '0
                  : NUMW'(GC_PERCENT * (2 * int'(gc_cap_reg) - 1));
        num_hi    = NUMW'(GC_PERCENT * (2 * int'(gc_cap_reg) + 1));
        dividend  = cmd.cap_lo ? {num_hi, {F{1'b0}}} : {num_lo, {F{1'b0}}};
        divisor   = {len_cap_reg, 1'b0};
        div_start = cmd.div_go_lo || cmd.cap_lo;
    end

    rqs_divider #(
        .DW  (DW),
        .DVW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // bin amount
    always_comb
    begin
        lo_i = lo_fx_reg[FXW-1:F];
        hi_i = hi_fx_reg[FXW-1:F];
        if (walk_bin_reg == lo_i)
        begin
            if (lo_i == hi_i)
                amt = hi_fx_reg - lo_fx_reg;
            else
                amt = FX_ONE - (lo_fx_reg & (FX_ONE - FXW'(1)));
        end
        else
        begin
            amt = ((walk_bin_reg == hi_i) ? (hi_fx_reg & (FX_ONE - FXW'(1))) : '0)
                + ((full_reg || walk_bin_reg < hi_i) ? FX_ONE : '0);
        end
    end

    // read-out select
    always_comb
    begin
        fetch_val = '0;
        fetch_err = 1'b1;
        case (item_tsel_reg)
            SEL_COUNTERS:
                if (32'(item_tidx_reg) < 32'(COUNTER_NUM))
                begin
                    fetch_val = DATA_W'(counters_reg[item_tidx_reg[1:0]]);
                    fetch_err = 1'b0;
                end
            SEL_LENGTH:
                if (32'(item_tidx_reg) < 32'(LH_DEPTH))
                begin
                    fetch_val = DATA_W'(lh_rdata);
                    fetch_err = 1'b0;
                end
            SEL_QUALITY:
                if (32'(item_tidx_reg) < 32'(QH_DEPTH))
                begin
                    fetch_val = DATA_W'(qh_rdata);
                    fetch_err = 1'b0;
                end
            SEL_GC:
                if (32'(item_tidx_reg) < 32'(GC_BIN_COUNT))
                begin
                    fetch_val = gc_rdata;
                    fetch_err = 1'b0;
                end
            SEL_BASES:
                if (32'(item_tidx_reg) < 32'(POS_ENT))
                begin
                    fetch_val = DATA_W'(bpc_rdata);
                    fetch_err = 1'b0;
                end
            SEL_QSUMS:
                if (32'(item_tidx_reg) < 32'(POS_ENT))
                begin
                    fetch_val = DATA_W'(qps_rdata);
                    fetch_err = 1'b0;
                end
            default:
            begin
                fetch_val = '0;
                fetch_err = 1'b1;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (clr_active && 32'(clr_idx_reg) < 32'(LH_DEPTH))
            lh_mem[PW'(clr_idx_reg)] <= '0;
        else if (cmd.fin_wr)
            lh_mem[pos_reg] <= lh_rdata + LEN_HIST_W'(1);
        lh_rdata <= lh_mem[lh_ra];
    end

    always_ff @(posedge clk)
    begin
        if (clr_active && 32'(clr_idx_reg) < 32'(QH_DEPTH))
            qh_mem[QAW'(clr_idx_reg)] <= '0;
        else if (cmd.base_wr && take)
            qh_mem[QAW'(qc)] <= qh_rdata + QHIST_W'(1);
        qh_rdata <= qh_mem[qh_ra];
    end

    always_ff @(posedge clk)
    begin
        if (clr_active && 32'(clr_idx_reg) < 32'(GC_BIN_COUNT))
            gc_mem[GAW'(clr_idx_reg)] <= '0;
        else if (cmd.gc_wr && walk_bin_reg < BINW'(GC_BIN_COUNT))
            gc_mem[GAW'(walk_bin_reg)] <= gc_rdata + GC_BIN_W'(amt);
        gc_rdata <= gc_mem[gc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (clr_active && 32'(clr_idx_reg) < 32'(POS_ENT))
            bpc_mem[SW'(clr_idx_reg)] <= '0;
        else if (cmd.base_wr && take)
            bpc_mem[slot] <= bpc_rdata + BPC_W'(1);
        bpc_rdata <= bpc_mem[pos_ra];
    end

    always_ff @(posedge clk)
    begin
        if (clr_active && 32'(clr_idx_reg) < 32'(POS_ENT))
            qps_mem[SW'(clr_idx_reg)] <= '0;
        else if (cmd.base_wr && take)
            qps_mem[slot] <= qps_rdata + QPS_W'(qc);
        qps_rdata <= qps_mem[pos_ra];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qoff_reg      <= QOFF_RESET;
            pos_reg       <= '0;
            rsmp_reg      <= 1'b0;
            gc_tally_reg  <= '0;
            at_tally_reg  <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < COUNTER_NUM; i++)
                counters_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wen)
                qoff_reg <= cfg_wdata;
            if (clr_active)
                clr_idx_reg <= clr_idx_reg + CW'(1);
            if (cmd.base_wr)
            begin
                rsmp_reg <= eff_smp;
                if (room)
                    pos_reg <= pos_reg + PW'(1);
                if (take && (code_c == BASE_C || code_c == BASE_G))
                    gc_tally_reg <= gc_tally_reg + PW'(1);
                else if (take && (code_c == BASE_A || code_c == BASE_T))
                    at_tally_reg <= at_tally_reg + PW'(1);
            end
            if (cmd.fin_wr)
            begin
                counters_reg[0] <= counters_reg[0] + COUNTER_W'(item_inreads_reg);
                counters_reg[1] <= counters_reg[1] + COUNTER_W'(1);
                if (rsmp_reg)
                    counters_reg[2] <= counters_reg[2] + COUNTER_W'(1);
                pos_reg      <= '0;
                rsmp_reg     <= 1'b0;
                gc_tally_reg <= '0;
                at_tally_reg <= '0;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_cmd_reg     <= s_tuser;
            item_code_reg    <= s_tdata[2:0];
            item_qchar_reg   <= s_tdata[10:3];
            item_nobase_reg  <= s_tdata[11];
            item_eor_reg     <= s_tlast;
            item_smp_reg     <= s_tdata[12];
            item_inreads_reg <= s_tdata[20:13];
            item_tsel_reg    <= s_tdata[23:21];
            item_tidx_reg    <= s_tdata[34:24];
        end
        if (cmd.fin_wr)
        begin
            gc_cap_reg  <= gc_tally_reg;
            len_cap_reg <= len_sum[PW-1:0];
            full_reg    <= (len_sum == {1'b0, gc_tally_reg});
        end
        if (cmd.cap_lo)
            lo_fx_reg <= FXW'(quotient);
        if (cmd.cap_hi)
            hi_fx_reg <= (quotient > DIV_TOP) ? FX_TOP : FXW'(quotient);
        if (cmd.gc_setup)
        begin
            walk_bin_reg <= lo_i;
            walk_end_reg <= full_reg ? BINW'(GC_PERCENT) : hi_i;
        end
        if (cmd.gc_wr)
            walk_bin_reg <= walk_bin_reg + BINW'(1);
        if (cmd.load_out)
        begin
            out_data_reg <= fetch_val;
            out_err_reg  <= fetch_err;
        end
    end

    always_comb
    begin
        status.clear_done = (clr_idx_reg == CW'(CLR_DEPTH - 1));
        status.is_fetch   = (item_cmd_reg == CMD_FETCH);
        status.finish     = item_nobase_reg || item_eor_reg;
        status.spread     = rsmp_reg && (len_sum != '0);
        status.div_done   = div_done;
        status.gc_last    = (walk_bin_reg == walk_end_reg);
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_READ_LEN))
        else $error("position beyond max read length");

    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_sum <= {1'b0, pos_reg})
        else $error("base tallies exceed position");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("output beat overwritten before taken");

endmodule
`default_nettype wire
